// ===== design/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types for the first-fit segment allocator
// Segment record, request and result records, request mode codes.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned AddrW = 32;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  // one free segment, inclusive bounds
  typedef struct packed {
    logic [AddrW-1:0] seg_start;
    logic [AddrW-1:0] seg_end;
  } seg_t;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] request_size;
    logic [AddrW-1:0] first_addr;
    logic [AddrW-1:0] last_addr;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [AddrW-1:0] block_first;
    logic [AddrW-1:0] block_last;
    logic             table_overflow;
  } res_t;

endpackage

// ===== design/ffsa_req_if.sv =====
// ----------------------------------------------------------------------------
// ffsa_req_if: request channel
// Valid/ready channel carrying one allocate or free request per transaction.
// ----------------------------------------------------------------------------
interface ffsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ffsa_pkg::AddrW-1:0]  request_size;
  logic [ffsa_pkg::AddrW-1:0]  first_addr;
  logic [ffsa_pkg::AddrW-1:0]  last_addr;

  modport source (output valid, mode, request_size, first_addr, last_addr, input ready);
  modport sink   (input valid, mode, request_size, first_addr, last_addr, output ready);
endinterface

// ===== design/ffsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffsa_rsp_if: result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface ffsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [ffsa_pkg::AddrW-1:0]  block_first;
  logic [ffsa_pkg::AddrW-1:0]  block_last;
  logic                        table_overflow;

  modport source (output valid, granted, block_first, block_last, table_overflow,
                  input ready);
  modport sink   (input valid, granted, block_first, block_last, table_overflow,
                  output ready);
endinterface

// ===== design/ffsa_seg_mem.sv =====
// ----------------------------------------------------------------------------
// ffsa_seg_mem: segment table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffsa_seg_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  ffsa_pkg::seg_t wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output ffsa_pkg::seg_t rdata_o
);

  ffsa_pkg::seg_t mem_q [Depth];
  ffsa_pkg::seg_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ffsa_engine.sv =====
// ----------------------------------------------------------------------------
// ffsa_engine: table sequencer
// Scans the segment table through the memory, decides the update and runs the
// shift passes for removing or inserting a segment.
// ----------------------------------------------------------------------------
module ffsa_engine #(
  parameter int unsigned MaxSegments = 64,
  parameter int unsigned IW = $clog2(MaxSegments),
  parameter int unsigned CW = $clog2(MaxSegments + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       top_valid_i,
  input  logic [ffsa_pkg::AddrW-1:0] top_i,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  ffsa_pkg::req_t             req_i,
  output logic                       done_o,
  output ffsa_pkg::res_t             res_o,
  input  logic                       out_free_i,
  output logic                       mem_we_o,
  output logic [IW-1:0]              mem_waddr_o,
  output ffsa_pkg::seg_t             mem_wdata_o,
  output logic                       mem_re_o,
  output logic [IW-1:0]              mem_raddr_o,
  input  ffsa_pkg::seg_t             mem_rdata_i
);

  localparam int unsigned AW = ffsa_pkg::AddrW;

  typedef enum logic [2:0] {
    StInit, StIdle, StScan, StDecide, StShDown, StShUp, StDone
  } state_e;

  state_e         state_q, state_d;
  ffsa_pkg::req_t req_q, req_d;
  ffsa_pkg::res_t res_q, res_d;
  ffsa_pkg::seg_t prev_q, prev_d, next_q, next_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  rd_idx_q, rd_idx_d;
  logic [CW-1:0]  p_q, p_d;
  logic [CW-1:0]  sh_idx_q, sh_idx_d;
  logic [IW-1:0]  chk_idx_q, chk_idx_d;
  logic [IW-1:0]  pend_addr_q, pend_addr_d;
  logic           chk_q, chk_d, pend_q, pend_d;
  logic           have_prev_q, have_prev_d, found_q, found_d;

  // helper values
  logic [AW-1:0]  size_m1, seg_len;
  logic           fit, exact, overlap, left, right, issue;
  logic [CW-1:0]  chk_idx_p1, p_p1, p_m1, sh_m1, sh_p1;

  assign size_m1    = req_q.request_size - 1'b1;
  assign seg_len    = mem_rdata_i.seg_end - mem_rdata_i.seg_start;
  assign fit        = size_m1 <= seg_len;
  assign exact      = size_m1 == seg_len;
  assign overlap    = (mem_rdata_i.seg_start <= req_q.last_addr) &&
                      (req_q.first_addr <= mem_rdata_i.seg_end);
  assign left       = have_prev_q &&
                      (({1'b0, prev_q.seg_end} + 1'b1) == {1'b0, req_q.first_addr});
  assign right      = found_q &&
                      ({1'b0, next_q.seg_start} == ({1'b0, req_q.last_addr} + 1'b1));
  assign chk_idx_p1 = CW'(chk_idx_q) + 1'b1;
  assign p_p1       = p_q + 1'b1;
  assign p_m1       = p_q - 1'b1;
  assign sh_m1      = sh_idx_q - 1'b1;
  assign sh_p1      = sh_idx_q + 1'b1;

  // next state and memory commands
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    prev_d      = prev_q;
    next_d      = next_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    p_d         = p_q;
    sh_idx_d    = sh_idx_q;
    chk_idx_d   = chk_idx_q;
    pend_addr_d = pend_addr_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    have_prev_d = have_prev_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    done_o      = 1'b0;
    issue       = 1'b0;

    case (state_q)
      // reload table with one segment covering the memory
      StInit: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '{seg_start: '0, seg_end: top_i};
        count_d     = top_valid_i ? CW'(1) : '0;
        state_d     = StIdle;
      end

      StIdle: begin
        if (req_valid_i) begin
          req_d       = req_i;
          res_d       = '0;
          have_prev_d = 1'b0;
          found_d     = 1'b0;
          p_d         = '0;
          rd_idx_d    = '0;
          chk_d       = 1'b0;
          if (req_i.mode == ffsa_pkg::ModeAlloc && req_i.request_size == '0) begin
            state_d = StDone;
          end else if (req_i.mode == ffsa_pkg::ModeFree &&
                       (req_i.first_addr > req_i.last_addr || !top_valid_i ||
                        req_i.last_addr > top_i)) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end

      // read entries in order, check the one read last cycle
      StScan: begin
        issue = rd_idx_q < count_q;
        if (issue) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_idx_q[IW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          chk_idx_d   = rd_idx_q[IW-1:0];
        end
        chk_d = issue;
        if (chk_q) begin
          if (req_q.mode == ffsa_pkg::ModeAlloc) begin
            if (fit) begin
              res_d = '{granted: 1'b1, block_first: mem_rdata_i.seg_start,
                        block_last: mem_rdata_i.seg_start + size_m1,
                        table_overflow: 1'b0};
              if (exact) begin
                sh_idx_d = chk_idx_p1;
                pend_d   = 1'b0;
                state_d  = StShDown;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = chk_idx_q;
                mem_wdata_o = '{seg_start: mem_rdata_i.seg_start + req_q.request_size,
                                seg_end: mem_rdata_i.seg_end};
                state_d     = StDone;
              end
            end
          end else begin
            if (overlap) begin
              state_d = StDone;
            end else if (mem_rdata_i.seg_start < req_q.first_addr) begin
              prev_d      = mem_rdata_i;
              have_prev_d = 1'b1;
              p_d         = chk_idx_p1;
            end else if (!found_q) begin
              found_d = 1'b1;
              next_d  = mem_rdata_i;
            end
          end
        end else if (!issue) begin
          state_d = (req_q.mode == ffsa_pkg::ModeAlloc) ? StDone : StDecide;
        end
      end

      // merge, extend or insert the freed block, or flag a table overflow
      StDecide: begin
        if (left && right) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = p_m1[IW-1:0];
          mem_wdata_o = '{seg_start: prev_q.seg_start, seg_end: next_q.seg_end};
          res_d.granted = 1'b1;
          sh_idx_d    = p_p1;
          pend_d      = 1'b0;
          state_d     = StShDown;
        end else if (left) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = p_m1[IW-1:0];
          mem_wdata_o = '{seg_start: prev_q.seg_start, seg_end: req_q.last_addr};
          res_d.granted = 1'b1;
          state_d     = StDone;
        end else if (right) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = p_q[IW-1:0];
          mem_wdata_o = '{seg_start: req_q.first_addr, seg_end: next_q.seg_end};
          res_d.granted = 1'b1;
          state_d     = StDone;
        end else if (count_q == CW'(MaxSegments)) begin
          res_d.table_overflow = 1'b1;
          state_d = StDone;
        end else begin
          res_d.granted = 1'b1;
          sh_idx_d = count_q;
          pend_d   = 1'b0;
          state_d  = StShUp;
        end
      end

      // remove an entry: move entries above it down by one
      StShDown: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_addr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (sh_idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = sh_idx_q[IW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = sh_m1[IW-1:0];
          sh_idx_d    = sh_p1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - 1'b1;
            state_d = StDone;
          end
        end
      end

      // open a gap: move entries from the top down to p up by one
      StShUp: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_addr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (sh_idx_q > p_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = sh_m1[IW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = sh_idx_q[IW-1:0];
          sh_idx_d    = sh_m1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = p_q[IW-1:0];
            mem_wdata_o = '{seg_start: req_q.first_addr, seg_end: req_q.last_addr};
            count_d     = count_q + 1'b1;
            state_d     = StDone;
          end
        end
      end

      // hand the result to the output register
      StDone: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase

    if (load_i) begin
      state_d = StInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      count_q     <= '0;
      chk_q       <= 1'b0;
      pend_q      <= 1'b0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_q       <= chk_d;
      pend_q      <= pend_d;
      have_prev_q <= have_prev_d;
      found_q     <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    prev_q      <= prev_d;
    next_q      <= next_d;
    rd_idx_q    <= rd_idx_d;
    p_q         <= p_d;
    sh_idx_q    <= sh_idx_d;
    chk_idx_q   <= chk_idx_d;
    pend_addr_q <= pend_addr_d;
  end

  assign req_ready_o = state_q == StIdle;
  assign res_o       = res_q;

endmodule

// ===== design/first_fit_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit allocator over a sorted free list
//
//   channel        dir  contents
//   req_i          in   mode, request_size, first_addr, last_addr
//   rsp_o          out  granted, block_first, block_last, table_overflow
//   memory_words   in   write enable + 32-bit size, no read-back
//
// One request at a time. A request scans the table, then a removal or
// insertion shifts entries through the memory port at one entry per cycle.
// After reset and after each memory_words write, the engine reloads entry 0;
// the request channel is held off meanwhile.
// The result register frees the engine; a stalled result blocks only the next
// result, not the next request's scan.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ffsa_req_if.sink                   req_i,
  ffsa_rsp_if.source                 rsp_o,
  input  logic                       memory_words_we_i,
  input  logic [ffsa_pkg::AddrW-1:0] memory_words_i
);

  localparam int unsigned AW = ffsa_pkg::AddrW;
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);

  logic [AW-1:0]  memory_words_q, top;
  logic           top_valid;
  ffsa_pkg::req_t req;
  ffsa_pkg::res_t res, out_q;
  logic           out_valid_q, out_free, done;
  logic           mem_we, mem_re;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  ffsa_pkg::seg_t mem_wdata, mem_rdata;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_words_q <= AW'(65536);
    end else if (memory_words_we_i) begin
      memory_words_q <= memory_words_i;
    end
  end

  // last valid address; a zero size register leaves no valid address
  assign top_valid = memory_words_q != '0;
  assign top       = memory_words_q - 1'b1;

  assign req = '{mode: req_i.mode, request_size: req_i.request_size,
                 first_addr: req_i.first_addr, last_addr: req_i.last_addr};

  ffsa_seg_mem #(
    .Depth (MAX_SEGMENTS),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffsa_engine #(
    .MaxSegments (MAX_SEGMENTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (memory_words_we_i),
    .top_valid_i (top_valid),
    .top_i       (top),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .done_o      (done),
    .res_o       (res),
    .out_free_i  (out_free),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // result register
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.granted        = out_q.granted;
  assign rsp_o.block_first    = out_q.block_first;
  assign rsp_o.block_last     = out_q.block_last;
  assign rsp_o.table_overflow = out_q.table_overflow;

  // checks
  a_cfg_holds_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    memory_words_we_i |=> !req_i.ready)
    else $error("request taken during table reload");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second transaction taken while one is in flight");

  a_grant_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.granted && rsp_o.table_overflow))
    else $error("grant and overflow together");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.granted |-> rsp_o.block_first == '0 && rsp_o.block_last == '0)
    else $error("refused transaction carries a block");

endmodule
